// ===== hdl/adcspi_pkg.sv =====
// shared types, constants and a helper function for the adc spi command slave
`timescale 1ns / 1ps

package adcspi_pkg;

  // sizes
  localparam int NUM_CHANNELS = 8;
  localparam int REG_COUNT    = 21;
  localparam int SLOT_COUNT   = 8;
  localparam int FRAME_BYTES  = 27;

  // item actions
  localparam logic [1:0] ACT_XCHG  = 2'd0;
  localparam logic [1:0] ACT_CSREL = 2'd1;
  localparam logic [1:0] ACT_STAGE = 2'd2;
  localparam logic [1:0] ACT_CONV  = 2'd3;

  // register addresses
  localparam logic [4:0] REG_ID          = 5'h00;
  localparam logic [4:0] REG_CONFIG1     = 5'h01;
  localparam logic [4:0] REG_CONFIG2     = 5'h02;
  localparam logic [4:0] REG_CONFIG3     = 5'h03;
  localparam logic [4:0] REG_CH1SET      = 5'h05;
  localparam logic [4:0] REG_CH8SET      = 5'h0C;
  localparam logic [4:0] REG_FAULT_STATP = 5'h12;
  localparam logic [4:0] REG_FAULT_STATN = 5'h13;
  localparam logic [4:0] REG_GPIO        = 5'h14;

  // register reset values
  localparam logic [7:0] RST_ID      = 8'hD2;
  localparam logic [7:0] RST_CONFIG1 = 8'h94;
  localparam logic [7:0] RST_CONFIG2 = 8'hE0;
  localparam logic [7:0] RST_CHSET   = 8'h10;
  localparam logic [7:0] RST_GPIO    = 8'h0F;

  // control from the command decoder to the storage blocks
  typedef struct packed {
    logic       stage_en;
    logic       latch_en;
    logic       wr_en;
    logic       regs_rst;
    logic [4:0] reg_addr;
    logic [7:0] wr_data;
    logic [4:0] frame_idx;
  } ctl_t;

  // power-up value of one register
  function automatic logic [7:0] reg_reset_val(input logic [4:0] addr);
    logic [7:0] v;
    v = 8'h00;
    case (addr) inside
      REG_ID:                   v = RST_ID;
      REG_CONFIG1:              v = RST_CONFIG1;
      REG_CONFIG2, REG_CONFIG3: v = RST_CONFIG2;
      [REG_CH1SET:REG_CH8SET]:  v = RST_CHSET;
      REG_GPIO:                 v = RST_GPIO;
      default:                  v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/adc_spi_command_register_slave.sv =====
// top level of the adc spi command slave: input and result registers around the decoder
//
//  channel  direction  payload                                          handshake
//  in_      input      action, mosi_byte, channel, sample                in_valid / in_stall
//  out_     output     miso_byte, data_ready, converting,                out_valid / out_stall
//                      continuous_mode, standby
//
//  an accepted item waits in the input register, is decoded straight out of it and
//  is captured in the result register when it advances (result register empty or out_stall low)
//  one item per cycle is sustained while out_stall is low; decode and reads are combinational
//  reset (rst_n low, synchronous) loads the register file defaults and clears samples
//  a stalled result holds; the input register still fills behind it, then in_stall rises
`timescale 1ns / 1ps

module adc_spi_command_register_slave import adcspi_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_action,
  input  logic [7:0]         in_mosi_byte,
  input  logic [2:0]         in_channel,
  input  logic signed [23:0] in_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_miso_byte,
  output logic               out_data_ready,
  output logic               out_converting,
  output logic               out_continuous_mode,
  output logic               out_standby
);

  logic               in_v_r;
  logic [1:0]         action_r;
  logic [7:0]         mosi_r;
  logic [2:0]         channel_r;
  logic signed [23:0] sample_r;
  logic               out_v_r;
  logic [7:0]         miso_r;
  logic               ready_r, conv_r, cont_r, stby_r;
  logic               advance;
  logic               accept;
  ctl_t               ctl;
  logic [7:0]         miso_nxt;
  logic               ready_nxt, conv_nxt, cont_nxt, stby_nxt;
  logic [7:0]         rd_data, stat_p, stat_n, gpio, frame_byte;

  // handshake
  assign advance  = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !advance;
  assign accept   = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (accept) begin
      in_v_r <= 1'b1;
    end else if (advance) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      action_r  <= in_action;
      mosi_r    <= in_mosi_byte;
      channel_r <= in_channel;
      sample_r  <= in_sample;
    end
  end

  // decoder
  adcspi_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .go              (advance),
    .action          (action_r),
    .mosi_byte       (mosi_r),
    .rd_data         (rd_data),
    .frame_byte      (frame_byte),
    .ctl             (ctl),
    .miso_byte       (miso_nxt),
    .data_ready      (ready_nxt),
    .converting      (conv_nxt),
    .continuous_mode (cont_nxt),
    .standby         (stby_nxt)
  );

  // register file
  adcspi_regfile u_regfile (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (ctl.wr_en),
    .regs_rst (ctl.regs_rst),
    .addr     (ctl.reg_addr),
    .wr_data  (ctl.wr_data),
    .rd_data  (rd_data),
    .stat_p   (stat_p),
    .stat_n   (stat_n),
    .gpio     (gpio)
  );

  // sample staging and frame
  adcspi_frame u_frame (
    .clk        (clk),
    .rst_n      (rst_n),
    .stage_en   (ctl.stage_en),
    .latch_en   (ctl.latch_en),
    .channel    (channel_r),
    .sample     (sample_r),
    .frame_idx  (ctl.frame_idx),
    .stat_p     (stat_p),
    .stat_n     (stat_n),
    .gpio       (gpio),
    .frame_byte (frame_byte)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      miso_r  <= miso_nxt;
      ready_r <= ready_nxt;
      conv_r  <= conv_nxt;
      cont_r  <= cont_nxt;
      stby_r  <= stby_nxt;
    end
  end

  assign out_valid           = out_v_r;
  assign out_miso_byte       = miso_r;
  assign out_data_ready      = ready_r;
  assign out_converting      = conv_r;
  assign out_continuous_mode = cont_r;
  assign out_standby         = stby_r;

  // checks
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_v_r |-> !in_stall) else $error("input stalled with empty result register");

  a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_v_r) else $error("advanced item did not reach result register");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_stall && in_v_r)) else $error("input stall without output stall");

endmodule

// ===== hdl/adcspi_regfile.sv =====
// register file with read-only entries and command reset
`timescale 1ns / 1ps

module adcspi_regfile import adcspi_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  logic       regs_rst,
  input  logic [4:0] addr,
  input  logic [7:0] wr_data,
  output logic [7:0] rd_data,
  output logic [7:0] stat_p,
  output logic [7:0] stat_n,
  output logic [7:0] gpio
);

  logic [7:0] regs_r [REG_COUNT];
  logic       in_range;
  logic       writable;

  // address checks
  assign in_range = ({1'b0, addr} < 6'(REG_COUNT));
  assign writable = in_range && (addr != REG_ID) && (addr != REG_FAULT_STATP)
                    && (addr != REG_FAULT_STATN);

  // storage
  always_ff @(posedge clk) begin
    if (!rst_n || regs_rst) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        regs_r[i] <= reg_reset_val(5'(i));
      end
    end else if (wr_en && writable) begin
      regs_r[addr] <= wr_data;
    end
  end

  // reads
  assign rd_data = in_range ? regs_r[addr] : 8'h00;
  assign stat_p  = regs_r[REG_FAULT_STATP];
  assign stat_n  = regs_r[REG_FAULT_STATN];
  assign gpio    = regs_r[REG_GPIO];

endmodule

// ===== hdl/adcspi_frame.sv =====
// staged and latched samples, and frame byte selection
`timescale 1ns / 1ps

module adcspi_frame import adcspi_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               stage_en,
  input  logic               latch_en,
  input  logic [2:0]         channel,
  input  logic signed [23:0] sample,
  input  logic [4:0]         frame_idx,
  input  logic [7:0]         stat_p,
  input  logic [7:0]         stat_n,
  input  logic [7:0]         gpio,
  output logic [7:0]         frame_byte
);

  logic [23:0] staged_r [SLOT_COUNT];
  logic [23:0] frame_r  [SLOT_COUNT];
  logic [4:0]  k;
  logic [8:0]  prod;
  logic [2:0]  slot;
  logic [4:0]  part_w;
  logic [23:0] word;
  logic [7:0]  smp_byte;

  // sample storage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        staged_r[i] <= '0;
        frame_r[i]  <= '0;
      end
    end else begin
      if (stage_en && ({1'b0, channel} < 4'(NUM_CHANNELS))) begin
        staged_r[channel] <= sample;
      end
      if (latch_en) begin
        frame_r <= staged_r;
      end
    end
  end

  // sample slot and byte within it: divide by three through multiply by 11/32
  always_comb begin
    k      = frame_idx - 5'd3;
    prod   = {4'd0, k} * 9'd11;
    slot   = prod[7:5];
    part_w = k - {1'b0, slot, 1'b0} - {2'b0, slot};
    word   = frame_r[slot];
    case (part_w[1:0])
      2'd0:    smp_byte = word[23:16];
      2'd1:    smp_byte = word[15:8];
      default: smp_byte = word[7:0];
    endcase
  end

  // status bytes first, then samples msb first
  always_comb begin
    case (frame_idx)
      5'd0:    frame_byte = {4'hC, stat_p[7:4]};
      5'd1:    frame_byte = {stat_p[3:0], stat_n[7:4]};
      5'd2:    frame_byte = {stat_n[3:0], gpio[7:4]};
      default: frame_byte = (frame_idx >= 5'(FRAME_BYTES)) ? 8'h00 : smp_byte;
    endcase
  end

endmodule

// ===== hdl/adcspi_ctrl.sv =====
// command decoder, transfer phase and mode flags
`timescale 1ns / 1ps

module adcspi_ctrl import adcspi_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       go,
  input  logic [1:0] action,
  input  logic [7:0] mosi_byte,
  input  logic [7:0] rd_data,
  input  logic [7:0] frame_byte,
  output ctl_t       ctl,
  output logic [7:0] miso_byte,
  output logic       data_ready,
  output logic       converting,
  output logic       continuous_mode,
  output logic       standby
);

  // phases
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_RCOUNT = 3'd1;
  localparam logic [2:0] PH_WCOUNT = 3'd2;
  localparam logic [2:0] PH_RDATA  = 3'd3;
  localparam logic [2:0] PH_WDATA  = 3'd4;
  localparam logic [2:0] PH_FRAME  = 3'd5;
  localparam logic [2:0] PH_SKIP   = 3'd6;

  // opcodes
  localparam logic [7:0] OP_WAKEUP  = 8'h02;
  localparam logic [7:0] OP_STANDBY = 8'h04;
  localparam logic [7:0] OP_RESET   = 8'h06;
  localparam logic [7:0] OP_START   = 8'h08;
  localparam logic [7:0] OP_STOP    = 8'h0A;
  localparam logic [7:0] OP_RDATAC  = 8'h10;
  localparam logic [7:0] OP_SDATAC  = 8'h11;
  localparam logic [7:0] OP_RDATA   = 8'h12;
  localparam logic [2:0] GRP_RREG   = 3'b001;
  localparam logic [2:0] GRP_WREG   = 3'b010;

  logic [2:0] phase_r, phase_nxt;
  logic [4:0] idx_r, idx_nxt;
  logic [4:0] ptr_r, ptr_nxt;
  logic [4:0] rem_r, rem_nxt;
  logic       ready_r, ready_nxt;
  logic       conv_r, conv_nxt;
  logic       cont_r, cont_nxt;
  logic       stby_r, stby_nxt;
  logic       regs_rst;
  logic       wr_en;
  logic       latch_en;
  logic [4:0] idx_inc;

  assign idx_inc = ((phase_r == PH_FRAME) ? idx_r : 5'd0) + 5'd1;

  // next state for one item
  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    ptr_nxt   = ptr_r;
    rem_nxt   = rem_r;
    ready_nxt = ready_r;
    conv_nxt  = conv_r;
    cont_nxt  = cont_r;
    stby_nxt  = stby_r;
    miso_byte = 8'h00;
    regs_rst  = 1'b0;
    wr_en     = 1'b0;
    latch_en  = 1'b0;
    case (action)
      ACT_XCHG: begin
        case (phase_r)
          PH_IDLE: begin
            if (cont_r && ready_r) begin
              // continuous readout starts with frame byte zero
              ready_nxt = 1'b0;
              miso_byte = frame_byte;
              idx_nxt   = idx_inc;
              phase_nxt = PH_FRAME;
            end else if (mosi_byte[7:5] == GRP_RREG) begin
              if (cont_r) begin
                phase_nxt = PH_SKIP;
              end else begin
                ptr_nxt   = mosi_byte[4:0];
                phase_nxt = PH_RCOUNT;
              end
            end else if (mosi_byte[7:5] == GRP_WREG) begin
              ptr_nxt   = mosi_byte[4:0];
              phase_nxt = PH_WCOUNT;
            end else begin
              case (mosi_byte)
                OP_WAKEUP:  stby_nxt = 1'b0;
                OP_STANDBY: stby_nxt = 1'b1;
                OP_RESET: begin
                  regs_rst  = 1'b1;
                  ready_nxt = 1'b0;
                  conv_nxt  = 1'b0;
                  cont_nxt  = 1'b1;
                  stby_nxt  = 1'b0;
                  phase_nxt = PH_IDLE;
                  idx_nxt   = 5'd0;
                  rem_nxt   = 5'd0;
                end
                OP_START:  conv_nxt = 1'b1;
                OP_STOP:   conv_nxt = 1'b0;
                OP_RDATAC: cont_nxt = 1'b1;
                OP_SDATAC: cont_nxt = 1'b0;
                OP_RDATA: begin
                  ready_nxt = 1'b0;
                  idx_nxt   = 5'd0;
                  phase_nxt = PH_FRAME;
                end
                default: ;
              endcase
            end
          end
          PH_RCOUNT, PH_WCOUNT: begin
            // count saturates at 31
            rem_nxt   = (mosi_byte > 8'd31) ? 5'd31 : mosi_byte[4:0];
            phase_nxt = (phase_r == PH_RCOUNT) ? PH_RDATA : PH_WDATA;
          end
          PH_RDATA, PH_WDATA: begin
            if (phase_r == PH_RDATA) begin
              miso_byte = rd_data;
            end else begin
              wr_en = 1'b1;
            end
            ptr_nxt = ptr_r + 5'd1;
            if (rem_r == 5'd0) begin
              phase_nxt = PH_IDLE;
              idx_nxt   = 5'd0;
            end else begin
              rem_nxt = rem_r - 5'd1;
            end
          end
          PH_FRAME: begin
            miso_byte = frame_byte;
            idx_nxt   = idx_inc;
          end
          default: begin
            phase_nxt = PH_IDLE;
            idx_nxt   = 5'd0;
            rem_nxt   = 5'd0;
          end
        endcase
        // readout ends after the last frame byte
        if (phase_nxt == PH_FRAME && idx_nxt >= 5'(FRAME_BYTES)) begin
          phase_nxt = PH_IDLE;
          idx_nxt   = 5'd0;
          rem_nxt   = 5'd0;
        end
      end
      ACT_CSREL: begin
        phase_nxt = PH_IDLE;
        idx_nxt   = 5'd0;
        rem_nxt   = 5'd0;
      end
      ACT_STAGE: ;
      default: begin
        if (conv_r) begin
          latch_en  = 1'b1;
          ready_nxt = 1'b1;
        end
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      idx_r   <= 5'd0;
      ptr_r   <= 5'd0;
      rem_r   <= 5'd0;
      ready_r <= 1'b0;
      conv_r  <= 1'b0;
      cont_r  <= 1'b1;
      stby_r  <= 1'b0;
    end else if (go) begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      ptr_r   <= ptr_nxt;
      rem_r   <= rem_nxt;
      ready_r <= ready_nxt;
      conv_r  <= conv_nxt;
      cont_r  <= cont_nxt;
      stby_r  <= stby_nxt;
    end
  end

  // control to storage, gated by the item advancing
  always_comb begin
    ctl.stage_en  = go && (action == ACT_STAGE);
    ctl.latch_en  = go && latch_en;
    ctl.wr_en     = go && wr_en;
    ctl.regs_rst  = go && regs_rst;
    ctl.reg_addr  = ptr_r;
    ctl.wr_data   = mosi_byte;
    ctl.frame_idx = (phase_r == PH_FRAME) ? idx_r : 5'd0;
  end

  // flags after this item
  assign data_ready      = ready_nxt;
  assign converting      = conv_nxt;
  assign continuous_mode = cont_nxt;
  assign standby         = stby_nxt;

endmodule
